// ----- rtl/core/rgb_led_chain_frame_writer_defines.svh -----
// ----------------------------------------------------------------------------
// RGB LED chain frame writer assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_CHAIN_FRAME_WRITER_DEFINES_SVH
`define RGB_LED_CHAIN_FRAME_WRITER_DEFINES_SVH

`ifndef SYNTH
`define RLCFW_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlcfw assertion failed");
`define RLCFW_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlcfw assertion failed");
`else
`define RLCFW_ASSERT_IMP(name, ante, cons)
`define RLCFW_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ----- rtl/core/rlcfw_pkg.sv -----
// ----------------------------------------------------------------------------
// rlcfw_pkg
// Types, constants and helpers for the RGB LED chain frame writer.
// ----------------------------------------------------------------------------
package rlcfw_pkg;

  localparam int unsigned BoardsDefault = 4;
  localparam int unsigned ValW          = 16;
  localparam int unsigned ColW          = 10;
  localparam int unsigned EntryW        = 3 * ColW;
  localparam int unsigned WordW         = 32;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [WordW-1:0] CmdReset =
    (WordW'(2) << 29) | (WordW'(100) << 20) | (WordW'(120) << 10) | WordW'(100);
  localparam logic [ColW-1:0]  MaxReset = 10'd1023;

  localparam logic [CfgIdxW-1:0] RegCommandWord = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxValue    = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_SEND
  } state_e;

  typedef logic [EntryW-1:0] entry_t;

  function automatic logic [ColW-1:0] clamp_colour(input logic signed [ValW-1:0] v,
                                                   input logic [ColW-1:0] max_v);
    logic [ColW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({{(ValW-ColW){1'b0}}, max_v})) begin
      res = max_v;
    end else begin
      res = v[ColW-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/rgb_led_chain_frame_writer.sv -----
// ----------------------------------------------------------------------------
// rgb_led_chain_frame_writer
// Stores clamped colours per board in two small RAMs and streams full frames.
// ----------------------------------------------------------------------------
// First word pair: an accepted input word moves the FSM through ST_FETCH (RAM read) and
// ST_LOAD (output registers) before out_valid_o rises. Frame: BOARDS colour pairs
// (ST_FETCH, ST_LOAD, ST_SEND each, RAM read) then BOARDS command pairs (ST_LOAD,
// ST_SEND each); no new input is taken until the frame ends. Reset: colour store
// reads as zero (per-entry valid bits), registers at reset values, no output pending.
module rgb_led_chain_frame_writer #(
  parameter int unsigned Boards = rlcfw_pkg::BoardsDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rlcfw_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rlcfw_pkg::WordW-1:0]           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [rlcfw_pkg::ValW-1:0]     board_a_i,
  input  logic signed [rlcfw_pkg::ValW-1:0]     red_a_i,
  input  logic signed [rlcfw_pkg::ValW-1:0]     green_a_i,
  input  logic signed [rlcfw_pkg::ValW-1:0]     blue_a_i,
  input  logic signed [rlcfw_pkg::ValW-1:0]     board_b_i,
  input  logic signed [rlcfw_pkg::ValW-1:0]     red_b_i,
  input  logic signed [rlcfw_pkg::ValW-1:0]     green_b_i,
  input  logic signed [rlcfw_pkg::ValW-1:0]     blue_b_i,
  input  logic                                  led_en_a_i,
  input  logic                                  led_en_b_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [rlcfw_pkg::WordW-1:0]           word_a_o,
  output logic [rlcfw_pkg::WordW-1:0]           word_b_o,
  output logic                                  is_command_o,
  output logic                                  latch_after_o,
  output logic                                  drive_enable_a_o,
  output logic                                  drive_enable_b_o,
  output logic                                  last_o
);
  import rlcfw_pkg::*;

`include "rgb_led_chain_frame_writer_defines.svh"

  localparam int unsigned AddrW = (Boards > 1) ? $clog2(Boards) : 1;
  localparam logic signed [ValW-1:0] BoardMax = ValW'(Boards - 1);
  localparam logic [AddrW-1:0] KLast = AddrW'(Boards - 1);

  state_e state_q, state_d;

  logic [WordW-1:0] command_q;
  logic [ColW-1:0]  max_q;

  entry_t mem_a [Boards];
  entry_t mem_b [Boards];
  logic [Boards-1:0] vld_a_q, vld_b_q;
  entry_t rd_a_q, rd_b_q;
  logic   rd_ok_a_q, rd_ok_b_q;

  logic [AddrW-1:0] k_q;
  logic             cmd_q;
  logic             en_a_q, en_b_q;
  logic             k_last;

  logic in_acc, rd_en, load_out, advance;
  logic [AddrW-1:0] wa_a, wa_b;
  entry_t wd_a, wd_b;

  logic             out_valid_q;
  logic [WordW-1:0] word_a_q, word_b_q;
  logic             is_cmd_q, latch_q, last_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign k_last      = (k_q == KLast);

  function automatic logic [AddrW-1:0] clamp_board(input logic signed [ValW-1:0] v);
    logic [AddrW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > BoardMax) begin
      res = KLast;
    end else begin
      res = v[AddrW-1:0];
    end
    return res;
  endfunction

  assign wa_a = clamp_board(board_a_i);
  assign wa_b = clamp_board(board_b_i);
  assign wd_a = {clamp_colour(green_a_i, max_q), clamp_colour(red_a_i, max_q),
                 clamp_colour(blue_a_i, max_q)};
  assign wd_b = {clamp_colour(green_b_i, max_q), clamp_colour(red_b_i, max_q),
                 clamp_colour(blue_b_i, max_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_q <= CmdReset;
      max_q     <= MaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegCommandWord: command_q <= cfg_data_i;
        RegMaxValue:    max_q     <= cfg_data_i[ColW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_a[wa_a] <= wd_a;
      mem_b[wa_b] <= wd_b;
    end
    if (rd_en) begin
      rd_a_q <= mem_a[k_q];
      rd_b_q <= mem_b[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= '0;
      vld_b_q   <= '0;
      rd_ok_a_q <= 1'b0;
      rd_ok_b_q <= 1'b0;
    end else begin
      if (in_acc) begin
        vld_a_q[wa_a] <= 1'b1;
        vld_b_q[wa_b] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_a_q <= vld_a_q[k_q];
        rd_ok_b_q <= vld_b_q[k_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    rd_en    = 1'b0;
    load_out = 1'b0;
    advance  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        load_out = 1'b1;
        state_d  = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall_i) begin
          advance = 1'b1;
          if (cmd_q && k_last) begin
            state_d = ST_IDLE;
          end else if (!cmd_q && !k_last) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      cmd_q       <= 1'b0;
      en_a_q      <= 1'b0;
      en_b_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        k_q    <= '0;
        cmd_q  <= 1'b0;
        en_a_q <= led_en_a_i;
        en_b_q <= led_en_b_i;
      end else if (advance) begin
        k_q <= k_last ? '0 : k_q + AddrW'(1);
        if (k_last) cmd_q <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (advance) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      word_a_q <= cmd_q ? command_q : (rd_ok_a_q ? WordW'(rd_a_q) : '0);
      word_b_q <= cmd_q ? command_q : (rd_ok_b_q ? WordW'(rd_b_q) : '0);
      is_cmd_q <= cmd_q;
      latch_q  <= k_last;
      last_q   <= cmd_q && k_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign word_a_o         = word_a_q;
  assign word_b_o         = word_b_q;
  assign is_command_o     = is_cmd_q;
  assign latch_after_o    = latch_q;
  assign drive_enable_a_o = en_a_q;
  assign drive_enable_b_o = en_b_q;
  assign last_o           = last_q;

  `RLCFW_ASSERT_IMP(a_acc_no_pending, in_acc, !out_valid_q)
  `RLCFW_ASSERT_IMP(a_no_rd_wr_overlap, rd_en, !in_acc)
  `RLCFW_ASSERT_IMP(a_valid_in_send, out_valid_q, state_q == ST_SEND)
  `RLCFW_ASSERT_IMP(a_last_is_latch, out_valid_q && last_q, is_cmd_q && latch_q)
  `RLCFW_ASSERT_NXT(a_last_to_idle, advance && cmd_q && k_last, state_q == ST_IDLE)

endmodule
